### hw/rtl/gifdp_pkg.sv
// gifdp_pkg: shared types, register codes and interlace tables for the
// gif deinterlace palette expander; no dependencies
package gifdp_pkg;

	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int COORD_W = 16;
	localparam int SCREEN_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_TOP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INTERLACED   = 3'd4;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;

	localparam logic [1:0] PASS_FIRST = 2'd0;
	localparam logic [1:0] PASS_LAST  = 2'd3;

	typedef struct packed {
		logic        mode;
		logic [7:0]  color_index;
		logic [23:0] palette_color;
	} in_word_t;

	typedef struct packed {
		logic [SCREEN_W-1:0] screen_x;
		logic [SCREEN_W-1:0] screen_y;
		logic [7:0]          blue;
		logic [7:0]          green;
		logic [7:0]          red;
		logic                last_pixel;
	} out_word_t;

	typedef struct packed {
		logic [COORD_W-1:0] image_left;
		logic [COORD_W-1:0] image_top;
		logic [COORD_W-1:0] image_width;
		logic [COORD_W-1:0] image_height;
		logic               interlaced;
	} cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               last;
	} pos_t;

	function automatic logic [3:0] pass_start(input logic [1:0] pass);
		case (pass)
			2'd0: pass_start = 4'd0;
			2'd1: pass_start = 4'd4;
			2'd2: pass_start = 4'd2;
			default: pass_start = 4'd1;
		endcase
	endfunction

	function automatic logic [3:0] pass_step(input logic [1:0] pass);
		case (pass)
			2'd0: pass_step = 4'd8;
			2'd1: pass_step = 4'd8;
			2'd2: pass_step = 4'd4;
			default: pass_step = 4'd2;
		endcase
	endfunction

endpackage

### hw/rtl/gifdp_position.sv
// gifdp_position: column, stored-row and interlace pass counters
// gives the image position of the current pixel; uses gifdp_pkg
module gifdp_position (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  gifdp_pkg::cfg_t cfg,
	output gifdp_pkg::pos_t pos
);
	import gifdp_pkg::*;

	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] srow_q;
	logic [COORD_W-1:0] cur_q;
	logic [1:0]         pass_q;

	logic [COORD_W-1:0] w_m1;
	logic [COORD_W-1:0] h_m1;
	logic [COORD_W-1:0] h_eff;
	logic               row_end;
	logic               image_end;
	logic [1:0]         pass_nxt;
	logic [COORD_W:0]   row_nxt;
	logic [COORD_W-1:0] cur_nxt;

	assign w_m1 = (cfg.image_width == '0) ? '0 : cfg.image_width - 1'b1;
	assign h_m1 = (cfg.image_height == '0) ? '0 : cfg.image_height - 1'b1;
	assign h_eff = (cfg.image_height == '0) ? COORD_W'(1) : cfg.image_height;

	assign row_end = col_q >= w_m1;
	assign image_end = row_end && (srow_q >= h_m1);

	assign pos.col = col_q;
	assign pos.row = cfg.interlaced ? cur_q : srow_q;
	assign pos.last = image_end;

	// next interlaced row, skipping passes with no row left
	always_comb begin
		pass_nxt = pass_q;
		row_nxt = {1'b0, cur_q} + (COORD_W+1)'(pass_step(pass_q));
		for (int i = 0; i < 3; i++) begin
			if (row_nxt >= {1'b0, h_eff} && pass_nxt != PASS_LAST) begin
				pass_nxt = pass_nxt + 2'd1;
				row_nxt = (COORD_W+1)'(pass_start(pass_nxt));
			end
		end
		cur_nxt = row_nxt[COORD_W] ? '1 : row_nxt[COORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			srow_q <= '0;
			cur_q <= '0;
			pass_q <= PASS_FIRST;
		end else if (advance) begin
			if (image_end) begin
				col_q <= '0;
				srow_q <= '0;
				cur_q <= '0;
				pass_q <= PASS_FIRST;
			end else if (row_end) begin
				col_q <= '0;
				srow_q <= srow_q + 1'b1;
				cur_q <= cur_nxt;
				pass_q <= pass_nxt;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && image_end |=> col_q == '0 && srow_q == '0 && cur_q == '0)
		else $error("counters not cleared after last pixel");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(col_q) && $stable(srow_q) && $stable(pass_q))
		else $error("counters moved without a pixel");

	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !row_end |=> col_q == $past(col_q) + 1'b1 && $stable(srow_q))
		else $error("column did not step");

endmodule

### hw/rtl/gif_deinterlace_palette_expander.sv
// gif_deinterlace_palette_expander: top level, config registers, palette
// memory and output register; uses gifdp_pkg and gifdp_position
//
//   channel   signals                          word
//   input     in_valid  in_ready  in_data      gifdp_pkg::in_word_t
//   output    out_valid out_ready out_data     gifdp_pkg::out_word_t
//   config    cfg_we    cfg_index cfg_data     16-bit register write
//
// one word per cycle while out_ready is high; a taken pixel shows
// on the output in the next cycle; a palette load gives no output word
// reset clears counters and output valid, presets config; palette not cleared
// while the output word waits, in_ready is low
module gif_deinterlace_palette_expander #(
	parameter int PALETTE_DEPTH = gifdp_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  gifdp_pkg::in_word_t                 in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output gifdp_pkg::out_word_t                out_data,
	input  logic                                cfg_we,
	input  logic [gifdp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gifdp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import gifdp_pkg::*;

	localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	cfg_t cfg_q;
	pos_t pos;

	logic [23:0] palette_mem [PALETTE_DEPTH];
	logic [23:0] rd_s1;
	logic        oob_s1;
	logic        valid_s1;
	logic [SCREEN_W-1:0] x_s1;
	logic [SCREEN_W-1:0] y_s1;
	logic        last_s1;

	logic        accept;
	logic        pixel_acc;
	logic        load_acc;
	logic        in_range;
	logic [IDX_W-1:0] idx;
	logic [23:0] color;

	assign in_ready = !valid_s1 || out_ready;
	assign accept = in_valid && in_ready;
	assign pixel_acc = accept && (in_data.mode == MODE_PIXEL);
	assign load_acc = accept && (in_data.mode == MODE_LOAD);
	assign in_range = {1'b0, in_data.color_index} < 9'(PALETTE_DEPTH);
	assign idx = in_data.color_index[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_left <= '0;
			cfg_q.image_top <= '0;
			cfg_q.image_width <= COORD_W'(1);
			cfg_q.image_height <= COORD_W'(1);
			cfg_q.interlaced <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_LEFT:   cfg_q.image_left <= cfg_data;
				REG_IMAGE_TOP:    cfg_q.image_top <= cfg_data;
				REG_IMAGE_WIDTH:  cfg_q.image_width <= cfg_data;
				REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data;
				REG_INTERLACED:   cfg_q.interlaced <= cfg_data[0];
				default: ;
			endcase
		end
	end

	gifdp_position u_position (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (pixel_acc),
		.cfg     (cfg_q),
		.pos     (pos)
	);

	// palette memory
	always_ff @(posedge clk) begin
		if (load_acc && in_range) begin
			palette_mem[idx] <= in_data.palette_color;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_acc) begin
			rd_s1 <= palette_mem[idx];
			oob_s1 <= !in_range;
			x_s1 <= {1'b0, cfg_q.image_left} + {1'b0, pos.col};
			y_s1 <= {1'b0, cfg_q.image_top} + {1'b0, pos.row};
			last_s1 <= pos.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= pixel_acc;
		end
	end

	assign color = oob_s1 ? '0 : rd_s1;

	assign out_valid = valid_s1;
	assign out_data.screen_x = x_s1;
	assign out_data.screen_y = y_s1;
	assign out_data.blue = color[7:0];
	assign out_data.green = color[15:8];
	assign out_data.red = color[23:16];
	assign out_data.last_pixel = last_s1;

	a_pixel_out: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_acc |=> out_valid)
		else $error("pixel gave no output word");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |=> !out_valid)
		else $error("palette load gave an output word");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output word waits");

endmodule
